// File: sv/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// shared constants, state codes and controller/datapath command types
// ----------------------------------------------------------------------------
package ttb_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int UNIT_WIDTH_DEF  = 16;
	localparam int DIFF_W          = 33;
	localparam int EDGE_W          = 31;
	localparam int MUL_W           = 32;
	localparam int PROD_W          = 64;
	localparam int CNT_W           = 6;
	localparam int SQRT_STEPS      = 32;

	localparam logic [3:0] MUL_CROSS_LAST = 4'd11;
	localparam logic [3:0] MUL_SQ0        = 4'd12;
	localparam logic [3:0] MUL_SQ_LAST    = 4'd14;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS,
		ST_CHECK,
		ST_LOADMAG,
		ST_NORM,
		ST_SQUARE,
		ST_SQRT,
		ST_DIV,
		ST_EMIT
	} ttb_state_t;

	typedef struct packed {
		logic       store_vtx;
		logic       slot;
		logic       load_tri;
		logic       mul_go;
		logic [3:0] mul_idx;
		logic       load_mag;
		logic       vec;
		logic       norm_step;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic [1:0] comp;
		logic       set_degen;
		logic       emit;
	} ttb_cmd_t;

	typedef struct packed {
		logic zero_vec;
		logic norm_done;
		logic out_free;
	} ttb_stat_t;

endpackage

// File: sv/ttb_ctrl.sv
// ----------------------------------------------------------------------------
// ttb_ctrl
// sequencer for vertex capture, cross products, normalization and output
// ----------------------------------------------------------------------------
module ttb_ctrl import ttb_pkg::*; #(
	parameter int UNIT_WIDTH = UNIT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last_vertex,
	output logic      in_stall,
	input  ttb_stat_t stat,
	output ttb_cmd_t  cmd
);

	localparam int QB = UNIT_WIDTH - 1;

	ttb_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             vec_q, vec_d;
	logic [1:0]       comp_q, comp_d;
	logic [1:0]       phase_q, phase_d;
	logic [1:0]       eff_ph;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vec_q   <= 1'b0;
			comp_q  <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vec_q   <= vec_d;
			comp_q  <= comp_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		vec_d    = vec_q;
		comp_d   = comp_q;
		phase_d  = phase_q;
		cmd      = '0;
		cmd.vec  = vec_q;
		cmd.comp = comp_q;
		in_stall = 1'b1;
		eff_ph   = (phase_q == 2'd3) ? 2'd0 : phase_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (eff_ph != 2'd2) begin
						if (last_vertex) begin
							phase_d = '0;
						end else begin
							cmd.store_vtx = 1'b1;
							cmd.slot      = eff_ph[0];
							phase_d       = eff_ph + 2'd1;
						end
					end else begin
						cmd.load_tri = 1'b1;
						phase_d      = '0;
						cnt_d        = '0;
						state_d      = ST_CROSS;
					end
				end
			end
			ST_CROSS: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q <= CNT_W'(MUL_CROSS_LAST)) begin
					cmd.mul_go  = 1'b1;
					cmd.mul_idx = cnt_q[3:0];
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.zero_vec) begin
					cmd.set_degen = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					vec_d   = 1'b0;
					state_d = ST_LOADMAG;
				end
			end
			ST_LOADMAG: begin
				cmd.load_mag = 1'b1;
				state_d      = ST_NORM;
			end
			ST_NORM: begin
				if (stat.norm_done) begin
					cnt_d   = '0;
					state_d = ST_SQUARE;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_SQUARE: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q <= CNT_W'(MUL_SQ_LAST - MUL_SQ0)) begin
					cmd.mul_go  = 1'b1;
					cmd.mul_idx = MUL_SQ0 + cnt_q[3:0];
				end else begin
					cnt_d   = '0;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == '0) begin
					cmd.sqrt_init = 1'b1;
				end else begin
					cmd.sqrt_step = 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS)) begin
						cnt_d   = '0;
						comp_d  = '0;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == '0) begin
					cmd.div_init = 1'b1;
				end else if (cnt_q <= CNT_W'(QB)) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.div_store = 1'b1;
					cnt_d         = '0;
					if (comp_q == 2'd2) begin
						if (!vec_q) begin
							vec_d   = 1'b1;
							state_d = ST_LOADMAG;
						end else begin
							state_d = ST_EMIT;
						end
					end else begin
						comp_d = comp_q + 2'd1;
					end
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/ttb_datapath.sv
// ----------------------------------------------------------------------------
// ttb_datapath
// vertex store, edge/texture deltas, shared multiplier, normalizer,
// iterative square root and divider, result and output registers
// ----------------------------------------------------------------------------
module ttb_datapath import ttb_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int UNIT_WIDTH  = UNIT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttb_cmd_t                      cmd,
	output ttb_stat_t                     stat,
	input  logic signed [COORD_WIDTH-1:0] position_x,
	input  logic signed [COORD_WIDTH-1:0] position_y,
	input  logic signed [COORD_WIDTH-1:0] position_z,
	input  logic signed [COORD_WIDTH-1:0] tex_u,
	input  logic signed [COORD_WIDTH-1:0] tex_v,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic signed [UNIT_WIDTH-1:0]  tangent_x,
	output logic signed [UNIT_WIDTH-1:0]  tangent_y,
	output logic signed [UNIT_WIDTH-1:0]  tangent_z,
	output logic signed [UNIT_WIDTH-1:0]  binormal_x,
	output logic signed [UNIT_WIDTH-1:0]  binormal_y,
	output logic signed [UNIT_WIDTH-1:0]  binormal_z,
	output logic                          degenerate
);

	localparam int QB = UNIT_WIDTH - 1;
	localparam int NW = UNIT_WIDTH + 30;

	logic signed [COORD_WIDTH-1:0] pos_q [2][3];
	logic signed [COORD_WIDTH-1:0] tex_q [2][2];
	logic signed [COORD_WIDTH-1:0] cur_pos [3];
	logic signed [EDGE_W-1:0]      e_q [6];
	logic signed [EDGE_W-1:0]      d_q [4];
	logic signed [DIFF_W-1:0]      ev [6];
	logic signed [DIFF_W-1:0]      dv [4];
	logic [1:0]                    sp, st;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	logic [3:0]               idx_s1;
	logic                     vld_s1;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] cr_q [6];
	logic [PROD_W-1:0]        sq_q;
	logic [2:0]               mj, mci;
	logic [1:0]               sk;

	logic [PROD_W-1:0] mag_q [3];
	logic [2:0]        sgn_q;
	logic [PROD_W-1:0] mor;

	logic [PROD_W-1:0] sqx_q, sqres_q, sqbit_q, sqtry;
	logic [31:0]       r;

	logic [NW-1:0]     num;
	logic [31:0]       rem_q;
	logic [QB-1:0]     nsh_q, q_q;
	logic [32:0]       dt;
	logic              dge;
	logic [UNIT_WIDTH-1:0] qx;

	logic signed [UNIT_WIDTH-1:0] res_q [6];
	logic                         degen_q;
	logic                         out_valid_q;
	logic signed [UNIT_WIDTH-1:0] out_q [6];

	function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_WIDTH-1:0] v);
		sx = DIFF_W'(v);
	endfunction

	function automatic logic [1:0] need(input logic signed [DIFF_W-1:0] v);
		if (v[DIFF_W-1] == v[DIFF_W-2] && v[DIFF_W-2] == v[DIFF_W-3])
			need = 2'd0;
		else if (v[DIFF_W-1] == v[DIFF_W-2])
			need = 2'd1;
		else
			need = 2'd2;
	endfunction

	assign cur_pos[0] = position_x;
	assign cur_pos[1] = position_y;
	assign cur_pos[2] = position_z;

	// edge and texture deltas, each set with its own common fit shift
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ev[i]     = sx(pos_q[1][i]) - sx(pos_q[0][i]);
			ev[3 + i] = sx(cur_pos[i]) - sx(pos_q[0][i]);
		end
		dv[0] = sx(tex_q[1][0]) - sx(tex_q[0][0]);
		dv[1] = sx(tex_q[1][1]) - sx(tex_q[0][1]);
		dv[2] = sx(tex_u) - sx(tex_q[0][0]);
		dv[3] = sx(tex_v) - sx(tex_q[0][1]);
		sp = '0;
		st = '0;
		for (int i = 0; i < 6; i++)
			if (need(ev[i]) > sp)
				sp = need(ev[i]);
		for (int i = 0; i < 4; i++)
			if (need(dv[i]) > st)
				st = need(dv[i]);
	end

	always_ff @(posedge clk) begin
		if (cmd.store_vtx) begin
			for (int i = 0; i < 3; i++)
				pos_q[cmd.slot][i] <= cur_pos[i];
			tex_q[cmd.slot][0] <= tex_u;
			tex_q[cmd.slot][1] <= tex_v;
		end
		if (cmd.load_tri) begin
			for (int i = 0; i < 6; i++)
				e_q[i] <= EDGE_W'(ev[i] >>> sp);
			for (int i = 0; i < 4; i++)
				d_q[i] <= EDGE_W'(dv[i] >>> st);
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mj    = 3'(cmd.mul_idx >> 1);
		mci   = (mj >= 3'd3) ? mj - 3'd3 : mj;
		sk    = 2'(cmd.mul_idx - MUL_SQ0);
		if (cmd.mul_idx >= MUL_SQ0) begin
			mul_a = {1'b0, mag_q[sk][EDGE_W-1:0]};
			mul_b = mul_a;
		end else begin
			unique case ({mj >= 3'd3, cmd.mul_idx[0]})
				2'b00: begin
					mul_a = MUL_W'(e_q[mci + 3'd3]);
					mul_b = MUL_W'(d_q[1]);
				end
				2'b01: begin
					mul_a = MUL_W'(e_q[mci]);
					mul_b = MUL_W'(d_q[3]);
				end
				2'b10: begin
					mul_a = MUL_W'(e_q[mci]);
					mul_b = MUL_W'(d_q[2]);
				end
				2'b11: begin
					mul_a = MUL_W'(e_q[mci + 3'd3]);
					mul_b = MUL_W'(d_q[0]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		idx_s1  <= cmd.mul_idx;
		if (vld_s1) begin
			if (idx_s1 >= MUL_SQ0) begin
				if (idx_s1 == MUL_SQ0)
					sq_q <= prod_s1;
				else
					sq_q <= sq_q + prod_s1;
			end else if (!idx_s1[0]) begin
				acc_q <= prod_s1;
			end else begin
				cr_q[idx_s1[3:1]] <= acc_q - prod_s1;
			end
		end
	end

	// normalize magnitudes so the largest lands in [2^30, 2^31)
	assign mor = mag_q[0] | mag_q[1] | mag_q[2];

	always_ff @(posedge clk) begin
		if (cmd.load_mag) begin
			for (int k = 0; k < 3; k++) begin
				if (cr_q[cmd.vec ? 3 + k : k] < 0)
					mag_q[k] <= PROD_W'(-cr_q[cmd.vec ? 3 + k : k]);
				else
					mag_q[k] <= PROD_W'(cr_q[cmd.vec ? 3 + k : k]);
				sgn_q[k] <= cr_q[cmd.vec ? 3 + k : k][PROD_W-1];
			end
		end else if (cmd.norm_step) begin
			for (int k = 0; k < 3; k++) begin
				priority if (|mor[PROD_W-1:39])
					mag_q[k] <= mag_q[k] >> 8;
				else if (|mor[PROD_W-1:31])
					mag_q[k] <= mag_q[k] >> 1;
				else if (!(|mor[PROD_W-1:22]))
					mag_q[k] <= mag_q[k] << 8;
				else
					mag_q[k] <= mag_q[k] << 1;
			end
		end
	end

	// bit-pair square root, one step per cycle
	assign sqtry = sqres_q + sqbit_q;
	assign r     = sqres_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sqx_q   <= sq_q;
			sqres_q <= '0;
			sqbit_q <= PROD_W'(1) << 62;
		end else if (cmd.sqrt_step) begin
			if (sqx_q >= sqtry) begin
				sqx_q   <= sqx_q - sqtry;
				sqres_q <= (sqres_q >> 1) + sqbit_q;
			end else begin
				sqres_q <= sqres_q >> 1;
			end
			sqbit_q <= sqbit_q >> 2;
		end
	end

	// restoring divider, one quotient bit per cycle
	assign num = (NW'(mag_q[cmd.comp][EDGE_W-1:0]) << (UNIT_WIDTH - 2)) + NW'(r[31:1]);
	assign dt  = {rem_q, nsh_q[QB-1]};
	assign dge = dt >= {1'b0, r};
	assign qx  = {1'b0, q_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= 32'(num[NW-1:QB]);
			nsh_q <= num[QB-1:0];
			q_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= dge ? 32'(dt - {1'b0, r}) : dt[31:0];
			nsh_q <= nsh_q << 1;
			q_q   <= {q_q[QB-2:0], dge};
		end
		if (cmd.div_store)
			res_q[cmd.vec ? 3'(cmd.comp) + 3'd3 : 3'(cmd.comp)] <=
				sgn_q[cmd.comp] ? -qx : qx;
		else if (cmd.set_degen)
			for (int i = 0; i < 6; i++)
				res_q[i] <= '0;
		if (cmd.load_tri)
			degen_q <= 1'b0;
		else if (cmd.set_degen)
			degen_q <= 1'b1;
		if (cmd.emit) begin
			for (int i = 0; i < 6; i++)
				out_q[i] <= res_q[i];
			degenerate <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.zero_vec  = (cr_q[0] == 0 && cr_q[1] == 0 && cr_q[2] == 0) ||
	                        (cr_q[3] == 0 && cr_q[4] == 0 && cr_q[5] == 0);
	assign stat.norm_done = !(|mor[PROD_W-1:31]) && mor[30];
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign tangent_x  = out_q[0];
	assign tangent_y  = out_q[1];
	assign tangent_z  = out_q[2];
	assign binormal_x = out_q[3];
	assign binormal_y = out_q[4];
	assign binormal_z = out_q[5];

endmodule

// File: sv/triangle_tangent_binormal_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_binormal_top: per-triangle tangent and binormal unit vectors
// the first two vertices of a triangle are stored; the third starts the run of
// cross products, normalization, square root and division for both vectors;
// throughput set by the shared multiplier, square root and divider; reset clears
// control and output valid asynchronously, stored vertices stay undefined
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_top import ttb_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int UNIT_WIDTH  = UNIT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] position_x,
	input  logic signed [COORD_WIDTH-1:0] position_y,
	input  logic signed [COORD_WIDTH-1:0] position_z,
	input  logic signed [COORD_WIDTH-1:0] tex_u,
	input  logic signed [COORD_WIDTH-1:0] tex_v,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [UNIT_WIDTH-1:0]  tangent_x,
	output logic signed [UNIT_WIDTH-1:0]  tangent_y,
	output logic signed [UNIT_WIDTH-1:0]  tangent_z,
	output logic signed [UNIT_WIDTH-1:0]  binormal_x,
	output logic signed [UNIT_WIDTH-1:0]  binormal_y,
	output logic signed [UNIT_WIDTH-1:0]  binormal_z,
	output logic                          degenerate
);

	ttb_cmd_t  cmd;
	ttb_stat_t stat;

	ttb_ctrl #(
		.UNIT_WIDTH(UNIT_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_vertex(last_vertex),
		.in_stall   (in_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	ttb_datapath #(
		.COORD_WIDTH(COORD_WIDTH),
		.UNIT_WIDTH (UNIT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.position_x(position_x),
		.position_y(position_y),
		.position_z(position_z),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.tangent_x (tangent_x),
		.tangent_y (tangent_y),
		.tangent_z (tangent_z),
		.binormal_x(binormal_x),
		.binormal_y(binormal_y),
		.binormal_z(binormal_z),
		.degenerate(degenerate)
	);

endmodule

// File: sv/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker
// port-level checks on the result channel of the top level
// ----------------------------------------------------------------------------
module ttb_checker import ttb_pkg::*; #(
	parameter int UNIT_WIDTH = UNIT_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [UNIT_WIDTH-1:0] tangent_x,
	input logic signed [UNIT_WIDTH-1:0] tangent_y,
	input logic signed [UNIT_WIDTH-1:0] tangent_z,
	input logic signed [UNIT_WIDTH-1:0] binormal_x,
	input logic signed [UNIT_WIDTH-1:0] binormal_y,
	input logic signed [UNIT_WIDTH-1:0] binormal_z,
	input logic                         degenerate
);

	localparam logic signed [UNIT_WIDTH-1:0] ONE = UNIT_WIDTH'(1) << (UNIT_WIDTH - 2);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled transaction dropped");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 0 && tangent_y == 0 && tangent_z == 0
			&& binormal_x == 0 && binormal_y == 0 && binormal_z == 0)
		else $error("degenerate transaction with nonzero vector");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> (tangent_x != 0 || tangent_y != 0 || tangent_z != 0)
			&& (binormal_x != 0 || binormal_y != 0 || binormal_z != 0))
		else $error("unit vector came out zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tangent_x <= ONE && tangent_x >= -ONE
			&& binormal_x <= ONE && binormal_x >= -ONE)
		else $error("component beyond one");

endmodule

bind triangle_tangent_binormal_top ttb_checker #(
	.UNIT_WIDTH(UNIT_WIDTH)
) u_ttb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tangent_x (tangent_x),
	.tangent_y (tangent_y),
	.tangent_z (tangent_z),
	.binormal_x(binormal_x),
	.binormal_y(binormal_y),
	.binormal_z(binormal_z),
	.degenerate(degenerate)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: triangle tangent/binormal block
// a directed table of vertices, then random meshes in three idling phases, are
// fed in; each result is checked field by field against the table's basis if
// it gives one, else a fixed-point tangent-space predictor, in order of arrival
// ----------------------------------------------------------------------------
module testbench;
	import ttb_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int UW = UNIT_WIDTH_DEF;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic signed [CW-1:0] px, py, pz, tu, tv;
		logic                 last;
	} vertex_t;

	typedef struct {
		logic signed [UW-1:0] tx, ty, tz, bx, by, bz;
		logic                 degen;
	} basis_t;

	typedef struct {
		vertex_t v;
		bit      typed;
		basis_t  r;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [CW-1:0] position_x, position_y, position_z, tex_u, tex_v;
	logic                 last_vertex;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [UW-1:0] tangent_x, tangent_y, tangent_z;
	logic signed [UW-1:0] binormal_x, binormal_y, binormal_z;
	logic                 degenerate;

	triangle_tangent_binormal_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.position_x(position_x), .position_y(position_y), .position_z(position_z),
		.tex_u(tex_u), .tex_v(tex_v), .last_vertex(last_vertex),
		.out_valid(out_valid), .out_stall(out_stall),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z),
		.degenerate(degenerate)
	);

	basis_t  basis_q[$];
	row_t    stim_rows[$];
	int      errors = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	bit      hold_req = 0;
	int      hold_left = 0;
	int      quiet_cycles = 0;

	// predictor state
	int                   tri_phase = 0;
	logic signed [CW-1:0] held_p[2][3];
	logic signed [CW-1:0] held_t[2][2];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic int fit_shift(input longint a0, a1, a2, a3, a4, a5, input int n);
		longint vals[6];
		longint t;
		bit ok;
		int s;
		vals = '{a0, a1, a2, a3, a4, a5};
		for (s = 0; s < 40; s++) begin
			ok = 1;
			for (int i = 0; i < n; i++) begin
				t = vals[i] >>> s;
				if (t < -(64'sd1 <<< 30) || t > ((64'sd1 <<< 30) - 1))
					ok = 0;
			end
			if (ok)
				return s;
		end
		return s;
	endfunction

	// returns 0 for a zero vector
	function automatic bit unit_dir(input longint c0, c1, c2,
			output logic signed [UW-1:0] o0, o1, o2);
		longint c[3];
		longint unsigned mag[3];
		longint unsigned m, s, r, q;
		logic signed [UW-1:0] o[3];
		c = '{c0, c1, c2};
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
			if (mag[i] > m)
				m = mag[i];
		end
		o0 = 0;
		o1 = 0;
		o2 = 0;
		if (m == 0)
			return 0;
		while (m >= (64'd1 << 31)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		s = 0;
		for (int i = 0; i < 3; i++)
			s += mag[i] * mag[i];
		r = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * (64'd1 << (UW - 2)) + (r >> 1)) / r;
			o[i] = c[i] < 0 ? UW'(-longint'(q)) : UW'(q);
		end
		o0 = o[0];
		o1 = o[1];
		o2 = o[2];
		return 1;
	endfunction

	// advances the predictor by one vertex; returns 1 when a triangle completes
	function automatic bit predict_basis(input vertex_t v, output basis_t r);
		longint e[6], d[4], tn[3], bn[3];
		int sp, st;
		bit tok, bok;
		r = '{default: '0};
		if (tri_phase < 2) begin
			if (v.last) begin
				tri_phase = 0;
				return 0;
			end
			held_p[tri_phase] = '{v.px, v.py, v.pz};
			held_t[tri_phase] = '{v.tu, v.tv};
			tri_phase++;
			return 0;
		end
		tri_phase = 0;
		e[0] = longint'(held_p[1][0]) - longint'(held_p[0][0]);
		e[1] = longint'(held_p[1][1]) - longint'(held_p[0][1]);
		e[2] = longint'(held_p[1][2]) - longint'(held_p[0][2]);
		e[3] = longint'(v.px) - longint'(held_p[0][0]);
		e[4] = longint'(v.py) - longint'(held_p[0][1]);
		e[5] = longint'(v.pz) - longint'(held_p[0][2]);
		d[0] = longint'(held_t[1][0]) - longint'(held_t[0][0]);
		d[1] = longint'(held_t[1][1]) - longint'(held_t[0][1]);
		d[2] = longint'(v.tu) - longint'(held_t[0][0]);
		d[3] = longint'(v.tv) - longint'(held_t[0][1]);
		sp = fit_shift(e[0], e[1], e[2], e[3], e[4], e[5], 6);
		st = fit_shift(d[0], d[1], d[2], d[3], 0, 0, 4);
		for (int i = 0; i < 6; i++)
			e[i] = e[i] >>> sp;
		for (int i = 0; i < 4; i++)
			d[i] = d[i] >>> st;
		for (int i = 0; i < 3; i++) begin
			tn[i] = e[3 + i] * d[1] - e[i] * d[3];
			bn[i] = e[i] * d[2] - e[3 + i] * d[0];
		end
		tok = unit_dir(tn[0], tn[1], tn[2], r.tx, r.ty, r.tz);
		bok = tok && unit_dir(bn[0], bn[1], bn[2], r.bx, r.by, r.bz);
		if (!bok) begin
			r = '{default: '0};
			r.degen = 1;
		end
		return 1;
	endfunction

	function automatic vertex_t mk_vtx(input longint x, y, z, u, w, input bit last);
		vertex_t v;
		v.px = CW'(x);
		v.py = CW'(y);
		v.pz = CW'(z);
		v.tu = CW'(u);
		v.tv = CW'(w);
		v.last = last;
		return v;
	endfunction

	function automatic void add_row(input vertex_t v, input bit typed, input basis_t r);
		row_t row;
		row.v = v;
		row.typed = typed;
		row.r = r;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		logic [CW-1:0] ext[4];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
		case ($urandom_range(5))
			0: return $urandom;
			1: return ext[$urandom_range(3)];
			2: return CW'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
			default: return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	function automatic vertex_t rand_vtx(input bit last);
		return mk_vtx(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), last);
	endfunction

	task automatic send_vtx(input vertex_t v, input bit typed, input basis_t typed_r);
		basis_t r;
		in_valid <= 1'b1;
		position_x <= v.px;
		position_y <= v.py;
		position_z <= v.pz;
		tex_u <= v.tu;
		tex_v <= v.tv;
		last_vertex <= v.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (predict_basis(v, r))
			basis_q.insert(basis_q.size(), typed ? typed_r : r);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (basis_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic rand_mesh(input int n_items);
		vertex_t v0;
		vertex_t v;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 8) begin
				// mesh ends on second or third vertex
				send_vtx(rand_vtx(0), 0, '{default: '0});
				send_vtx(rand_vtx($urandom_range(1)), 0, '{default: '0});
				if (tri_phase != 0)
					send_vtx(rand_vtx(1), 0, '{default: '0});
				sent += 3;
			end else begin
				v0 = rand_vtx(0);
				send_vtx(v0, 0, '{default: '0});
				send_vtx(rand_vtx(0), 0, '{default: '0});
				v = rand_vtx($urandom_range(9) == 0);
				if ($urandom_range(19) == 0)
					v = mk_vtx(v0.px, v0.py, v0.pz, v0.tu, v0.tv, v.last);
				send_vtx(v, 0, '{default: '0});
				sent += 3;
			end
		end
	endtask

	function automatic void check_field(input string name, input longint exp, act);
		if (exp != act) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
		end
	endfunction

	always @(posedge clk) begin
		basis_t e;
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (basis_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual tangent %0d %0d %0d",
					$time, tangent_x, tangent_y, tangent_z);
			end else begin
				e = basis_q.pop_front();
				check_field("tangent_x", e.tx, tangent_x);
				check_field("tangent_y", e.ty, tangent_y);
				check_field("tangent_z", e.tz, tangent_z);
				check_field("binormal_x", e.bx, binormal_x);
				check_field("binormal_y", e.by, binormal_y);
				check_field("binormal_z", e.bz, binormal_z);
				check_field("degenerate", e.degen, degenerate);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		basis_t unit_r, zero_r, none_r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		position_x = '0;
		position_y = '0;
		position_z = '0;
		tex_u = '0;
		tex_v = '0;
		last_vertex = 1'b0;
		none_r = '{default: '0};
		unit_r = '{default: '0};
		unit_r.tx = -16384;
		unit_r.by = -16384;
		zero_r = '{default: '0};
		zero_r.degen = 1;

		// axis-aligned unit triangle
		add_row(mk_vtx(0, 0, 0, 0, 0, 0), 0, none_r);
		add_row(mk_vtx(65536, 0, 0, 65536, 0, 0), 0, none_r);
		add_row(mk_vtx(0, 65536, 0, 0, 65536, 0), 1, unit_r);
		// three identical vertices
		add_row(mk_vtx(5, 6, 7, 8, 9, 0), 0, none_r);
		add_row(mk_vtx(5, 6, 7, 8, 9, 0), 0, none_r);
		add_row(mk_vtx(5, 6, 7, 8, 9, 0), 1, zero_r);
		// mesh ends on first vertex, then on second
		add_row(mk_vtx(1, 2, 3, 4, 5, 1), 0, none_r);
		add_row(mk_vtx(1, 2, 3, 4, 5, 0), 0, none_r);
		add_row(mk_vtx(-1, -2, -3, -4, -5, 1), 0, none_r);
		// last mark completing a triangle
		add_row(mk_vtx(0, 0, 0, 0, 0, 0), 0, none_r);
		add_row(mk_vtx(65536, 0, 0, 65536, 0, 0), 0, none_r);
		add_row(mk_vtx(0, 65536, 0, 0, 65536, 1), 1, unit_r);
		// coordinate extremes
		add_row(mk_vtx(-2147483648, -2147483648, -2147483648, -2147483648, 0, 0), 0, none_r);
		add_row(mk_vtx(2147483647, 2147483647, 0, 2147483647, 2147483647, 0), 0, none_r);
		add_row(mk_vtx(0, -2147483648, 2147483647, 0, -2147483648, 0), 0, none_r);
		add_row(mk_vtx(2147483647, -2147483648, 2147483647, -2147483648, 2147483647, 0),
			0, none_r);
		add_row(mk_vtx(-2147483648, 2147483647, -2147483648, 2147483647, -2147483648, 0),
			0, none_r);
		add_row(mk_vtx(-1, -1, -1, -1, -1, 0), 0, none_r);
		// flat texture mapping gives no tangent
		add_row(mk_vtx(0, 0, 0, 77, 77, 0), 0, none_r);
		add_row(mk_vtx(100, 0, 0, 77, 77, 0), 0, none_r);
		add_row(mk_vtx(0, 100, 0, 77, 77, 0), 1, zero_r);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_vtx(stim_rows[i].v, stim_rows[i].typed, stim_rows[i].r);
		drain();

		send_idle_pct = 12;
		recv_idle_pct = 51;
		rand_mesh(660);
		drain();

		send_idle_pct = 51;
		recv_idle_pct = 12;
		hold_req = 1;
		rand_mesh(660);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		rand_mesh(660);
		drain();

		repeat (300) @(posedge clk);
		if (errors == 0 && basis_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
